// ===== src/two_rotor_enigma_cipher_top_assert.svh =====
// Assertion macros for the two-rotor cipher top level.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef TWO_ROTOR_ENIGMA_CIPHER_TOP_ASSERT_SVH
`define TWO_ROTOR_ENIGMA_CIPHER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define TEC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define TEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TEC_ASSERT_NOW(label, ante, cons, msg)
`define TEC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/tre_pkg.sv =====
// Shared constants, codes, stage payload type and mod-N helpers for the cipher.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tre_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int LW            = 5;                       // letter field width
    localparam int IDX_W         = $clog2(ALPHABET_SIZE);   // table address width

    localparam logic [LW:0] N_W         = (LW + 1)'(ALPHABET_SIZE);
    localparam logic [LW-1:0] N_LAST    = LW'(ALPHABET_SIZE - 1);
    localparam logic [7:0]  LETTER_BASE = 8'h61;

    localparam logic       CMD_LOAD   = 1'b0;
    localparam logic       CMD_CIPHER = 1'b1;

    localparam logic [1:0] SEL_ROTOR1 = 2'd0;
    localparam logic [1:0] SEL_ROTOR2 = 2'd1;
    localparam logic [1:0] SEL_REFL   = 2'd2;

    typedef struct packed {
        logic          ld;     // accepted wiring write
        logic          ltr;    // cipher item carrying a letter
        logic [1:0]    sel;
        logic [LW-1:0] idx;
        logic [LW-1:0] val;
        logic [7:0]    chr;
        logic [LW-1:0] p1;
        logic [LW-1:0] p2;
        logic [LW-1:0] d21;    // (p2 - p1) mod N
        logic [LW-1:0] d12;    // (p1 - p2) mod N
    } t_stage;

    // Operands below N.
    function automatic logic [LW-1:0] add_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= N_W) begin
            s = s - N_W;
        end
        return s[LW-1:0];
    endfunction

    function automatic logic [LW-1:0] sub_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} - {1'b0, b};
        if (a < b) begin
            s = s + N_W;
        end
        return s[LW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== src/tre_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tre_ram #(
    parameter int DEPTH = 26,
    parameter int WIDTH = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/two_rotor_enigma_cipher_top.sv =====
// Two-rotor substitution cipher: loadable wiring in five small RAMs, one per table lookup.
// Depends on tre_pkg, tre_ram and two_rotor_enigma_cipher_top_assert.svh.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+----------------------------------
//   in      | sink      | i_in_valid / o_in_ready     | cmd, table_sel, entry_index,
//           |           |                             | entry_value, char_in
//   out     | source    | o_out_valid / i_out_ready   | char_out (one beat per cipher item)
//
// One beat per cycle in unless the output stalls; stages r_stg[0..4] feed r_out_valid. The
// chain of five table lookups sets the depth: each table is one RAM read once per
// beat in its own stage, and a wiring write lands in the stage that reads that table.
// Reset clears the stage valid bits, the output valid bit and both rotor positions;
// wiring RAMs are not cleared. While the output register holds an untaken beat,
// the whole pipeline and the input hold.
`timescale 1ns / 1ps
`default_nettype none

`include "two_rotor_enigma_cipher_top_assert.svh"

module two_rotor_enigma_cipher_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic       i_cmd,
    input  wire logic [1:0] i_table_sel,
    input  wire logic [4:0] i_entry_index,
    input  wire logic [4:0] i_entry_value,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_char_out
);

    localparam int LW    = tre_pkg::LW;
    localparam int IDX_W = tre_pkg::IDX_W;
    localparam int NSTG  = 5;

    logic w_en;
    logic w_acc;
    logic w_in_ld;
    logic w_in_ltr;
    logic w_in_vld;
    logic [7:0] w_diff;
    logic [LW-1:0] w_x0;

    logic [LW-1:0] r_pos1;
    logic [LW-1:0] r_pos2;
    logic [LW-1:0] n_pos1;
    logic [LW-1:0] n_pos2;

    logic [NSTG-1:0]   r_vld;
    tre_pkg::t_stage   r_stg [0:NSTG-1];
    tre_pkg::t_stage   n_stg;

    logic              r_out_valid;
    logic [7:0]        r_out_char;
    logic [LW-1:0]     w_x5;

    logic [NSTG-1:0]   w_we;
    logic [LW-1:0]     w_waddr [0:NSTG-1];
    logic [LW-1:0]     w_wdata [0:NSTG-1];
    logic [LW-1:0]     w_raddr [0:NSTG-1];
    logic [LW-1:0]     w_rdata [0:NSTG-1];

    // Whole pipeline advances unless a finished beat waits at the output.
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;

    assign w_diff   = i_char_in - tre_pkg::LETTER_BASE;
    assign w_in_ltr = (i_cmd == tre_pkg::CMD_CIPHER) && (i_char_in >= tre_pkg::LETTER_BASE)
                      && (w_diff < 8'(tre_pkg::ALPHABET_SIZE));
    assign w_x0     = w_in_ltr ? w_diff[LW-1:0] : '0;
    assign w_in_ld  = (i_cmd == tre_pkg::CMD_LOAD)
                      && ((i_table_sel == tre_pkg::SEL_ROTOR1)
                          || (i_table_sel == tre_pkg::SEL_ROTOR2)
                          || (i_table_sel == tre_pkg::SEL_REFL))
                      && ({1'b0, i_entry_index} < tre_pkg::N_W)
                      && ({1'b0, i_entry_value} < tre_pkg::N_W);
    // Loads that are out of range drop here and never enter the pipeline.
    assign w_in_vld = (i_cmd == tre_pkg::CMD_CIPHER) || w_in_ld;

    always_comb begin
        n_stg.ld  = w_in_ld;
        n_stg.ltr = w_in_ltr;
        n_stg.sel = i_table_sel;
        n_stg.idx = i_entry_index;
        n_stg.val = i_entry_value;
        n_stg.chr = i_char_in;
        n_stg.p1  = r_pos1;
        n_stg.p2  = r_pos2;
        n_stg.d21 = tre_pkg::sub_mod(r_pos2, r_pos1);
        n_stg.d12 = tre_pkg::sub_mod(r_pos1, r_pos2);
    end

    // Step rotor one per letter, rotor two on the wrap; a write clears both.
    always_comb begin
        n_pos1 = r_pos1;
        n_pos2 = r_pos2;
        if (w_acc && w_in_ld) begin
            n_pos1 = '0;
            n_pos2 = '0;
        end else if (w_acc && w_in_ltr) begin
            if (r_pos1 == tre_pkg::N_LAST) begin
                n_pos1 = '0;
                n_pos2 = (r_pos2 == tre_pkg::N_LAST) ? '0 : r_pos2 + 1'b1;
            end else begin
                n_pos1 = r_pos1 + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos1      <= '0;
            r_pos2      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos1 <= n_pos1;
            r_pos2 <= n_pos2;
            if (w_en) begin
                r_vld       <= {r_vld[NSTG-2:0], w_acc && w_in_vld};
                r_out_valid <= r_vld[NSTG-1] && !r_stg[NSTG-1].ld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_stg[0] <= n_stg;
            for (int k = 1; k < NSTG; k++) begin
                r_stg[k] <= r_stg[k-1];
            end
            r_out_char <= r_stg[NSTG-1].ltr ? (8'(w_x5) + tre_pkg::LETTER_BASE)
                                            : r_stg[NSTG-1].chr;
        end
    end

    // Read addresses: table k is read by the beat entering r_stg[k]; its data comes
    // back with that beat in r_stg[k].
    assign w_raddr[0] = tre_pkg::add_mod(w_x0, r_pos1);
    assign w_raddr[1] = tre_pkg::add_mod(w_rdata[0], r_stg[0].d21);
    assign w_raddr[2] = tre_pkg::sub_mod(w_rdata[1], r_stg[1].p2);
    assign w_raddr[3] = tre_pkg::add_mod(w_rdata[2], r_stg[2].p2);
    assign w_raddr[4] = tre_pkg::add_mod(w_rdata[3], r_stg[3].d12);
    assign w_x5       = tre_pkg::sub_mod(w_rdata[4], r_stg[4].p1);

    // Each table is written in the stage that reads it, so every beat sees the
    // writes of earlier beats only. A stage holds one beat, so a read and a write
    // that meet at a table in the same cycle come from the same beat.
    assign w_we[0]    = w_acc && w_in_ld && (i_table_sel == tre_pkg::SEL_ROTOR1);
    assign w_waddr[0] = i_entry_index;
    assign w_wdata[0] = i_entry_value;

    assign w_we[1]    = w_en && r_vld[0] && r_stg[0].ld && (r_stg[0].sel == tre_pkg::SEL_ROTOR2);
    assign w_waddr[1] = r_stg[0].idx;
    assign w_wdata[1] = r_stg[0].val;

    assign w_we[2]    = w_en && r_vld[1] && r_stg[1].ld && (r_stg[1].sel == tre_pkg::SEL_REFL);
    assign w_waddr[2] = r_stg[1].idx;
    assign w_wdata[2] = r_stg[1].val;

    // Inverse maps: address by value, store the index.
    assign w_we[3]    = w_en && r_vld[2] && r_stg[2].ld && (r_stg[2].sel == tre_pkg::SEL_ROTOR2);
    assign w_waddr[3] = r_stg[2].val;
    assign w_wdata[3] = r_stg[2].idx;

    assign w_we[4]    = w_en && r_vld[3] && r_stg[3].ld && (r_stg[3].sel == tre_pkg::SEL_ROTOR1);
    assign w_waddr[4] = r_stg[3].val;
    assign w_wdata[4] = r_stg[3].idx;

    for (genvar g = 0; g < NSTG; g++) begin : g_tbl
        tre_ram #(
            .DEPTH (tre_pkg::ALPHABET_SIZE),
            .WIDTH (LW)
        ) u_tbl (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr[g][IDX_W-1:0]),
            .i_wdata (w_wdata[g]),
            .i_re    (w_en),
            .i_raddr (w_raddr[g][IDX_W-1:0]),
            .o_rdata (w_rdata[g])
        );
    end

    assign o_out_valid = r_out_valid;
    assign o_char_out  = r_out_char;

    `TEC_ASSERT_NEXT(a_load_clears_pos, w_acc && w_in_ld, (r_pos1 == '0) && (r_pos2 == '0), "accepted wiring write did not clear rotor positions")
    `TEC_ASSERT_NEXT(a_pos2_steps_on_wrap, w_acc && !w_in_ld && (r_pos1 != tre_pkg::N_LAST), $stable(r_pos2), "rotor two moved without rotor one wrapping")
    `TEC_ASSERT_NEXT(a_stall_holds_pipe, !w_en, $stable(r_vld) && $stable(r_pos1) && $stable(r_pos2), "pipeline moved during an output stall")
    `TEC_ASSERT_NOW(a_refl_not_inverse, r_vld[2] && r_stg[2].ld && (r_stg[2].sel == tre_pkg::SEL_REFL), !w_we[3], "reflector write reached the inverse stage")

endmodule

`default_nettype wire

// ===== test/tb_two_rotor_enigma_cipher_top.sv =====
// Self-checking bench for two_rotor_enigma_cipher_top: queued wiring loads and cipher bytes,
// random idling on both channels, char_out checked against an in-bench rotor predictor.
// Depends on tre_pkg and the cipher top level.
`timescale 1ns / 1ps

module tb_two_rotor_enigma_cipher_top;

    localparam int         N            = tre_pkg::ALPHABET_SIZE;
    localparam logic [1:0] SEL_NONE     = 2'd3;     // table code the block drops
    localparam int         RANDOM_ITEMS = 740;
    localparam int         LONG_TEXT    = 680;      // enough letters to wrap rotor two
    localparam int         DRAIN_CYCLES = 40;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic       cmd;
        logic [1:0] sel;
        logic [4:0] idx;
        logic [4:0] val;
        logic [7:0] ch;
    } t_cipher_beat;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       i_cmd         = 1'b0;
    logic [1:0] i_table_sel   = 2'd0;
    logic [4:0] i_entry_index = 5'd0;
    logic [4:0] i_entry_value = 5'd0;
    logic [7:0] i_char_in     = 8'd0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_char_out;

    two_rotor_enigma_cipher_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_table_sel   (i_table_sel),
        .i_entry_index (i_entry_index),
        .i_entry_value (i_entry_value),
        .i_char_in     (i_char_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_char_out    (o_char_out)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: wiring tables, inverse maps and rotor positions.
    int rotor1_fwd [N];
    int rotor1_rev [N];
    int rotor2_fwd [N];
    int rotor2_rev [N];
    int reflect_to [N];
    int rotor1_pos = 0;
    int rotor2_pos = 0;

    t_cipher_beat beat_backlog [$];
    logic [7:0]   char_expected [$];

    t_cipher_beat live_beat;
    int  in_hold  = 0;
    bit  in_calm  = 1'b0;
    int  out_hold = 0;
    bit  out_calm = 1'b0;

    int  stim_count     = 0;
    int  beats_in       = 0;
    int  loads_applied  = 0;
    int  letters_done   = 0;
    int  results_seen   = 0;
    int  rotor2_wraps   = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;

    function automatic int enter_rotor(input int x, input int pos);
        return (x + pos) % N;
    endfunction

    function automatic int leave_rotor(input int v, input int pos);
        return (v + N - pos) % N;
    endfunction

    task automatic predict_beat(input t_cipher_beat b);
        int x;
        int c;
        beats_in++;
        if (b.cmd == tre_pkg::CMD_LOAD) begin
            if (b.sel == SEL_NONE || b.idx >= N || b.val >= N) begin
                return;
            end
            if (b.sel == tre_pkg::SEL_ROTOR1) begin
                rotor1_fwd[b.idx] = b.val;
                rotor1_rev[b.val] = b.idx;
            end else if (b.sel == tre_pkg::SEL_ROTOR2) begin
                rotor2_fwd[b.idx] = b.val;
                rotor2_rev[b.val] = b.idx;
            end else begin
                reflect_to[b.idx] = b.val;
            end
            rotor1_pos = 0;
            rotor2_pos = 0;
            loads_applied++;
            return;
        end
        c = b.ch;
        if (c >= tre_pkg::LETTER_BASE && c - tre_pkg::LETTER_BASE < N) begin
            x = c - tre_pkg::LETTER_BASE;
            x = leave_rotor(rotor1_fwd[enter_rotor(x, rotor1_pos)], rotor1_pos);
            x = leave_rotor(rotor2_fwd[enter_rotor(x, rotor2_pos)], rotor2_pos);
            x = reflect_to[x];
            x = leave_rotor(rotor2_rev[enter_rotor(x, rotor2_pos)], rotor2_pos);
            x = leave_rotor(rotor1_rev[enter_rotor(x, rotor1_pos)], rotor1_pos);
            c = tre_pkg::LETTER_BASE + x;
            // step rotor one, carry into rotor two on wrap
            rotor1_pos = (rotor1_pos + 1) % N;
            if (rotor1_pos == 0) begin
                rotor2_pos = (rotor2_pos + 1) % N;
                if (rotor2_pos == 0) begin
                    rotor2_wraps++;
                end
            end
            letters_done++;
        end
        char_expected.push_back(8'(c));
    endtask

    // ---------------- stimulus builders ----------------

    task automatic push_text(input logic [7:0] ch);
        t_cipher_beat b;
        b.cmd = tre_pkg::CMD_CIPHER;
        b.sel = 2'($urandom_range(0, 3));
        b.idx = 5'($urandom_range(0, 31));
        b.val = 5'($urandom_range(0, 31));
        b.ch  = ch;
        beat_backlog.push_back(b);
        stim_count++;
    endtask

    task automatic push_load(input logic [1:0] sel, input int idx, input int val);
        t_cipher_beat b;
        b.cmd = tre_pkg::CMD_LOAD;
        b.sel = sel;
        b.idx = 5'(idx);
        b.val = 5'(val);
        b.ch  = 8'($urandom_range(0, 255));
        beat_backlog.push_back(b);
        if (sel != SEL_NONE && idx < N && val < N) begin
            stim_count++;
        end
    endtask

    function automatic logic [7:0] pick_letter();
        return tre_pkg::LETTER_BASE + 8'($urandom_range(0, N - 1));
    endfunction

    function automatic logic [7:0] pick_symbol();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: b = " ";
            1: b = 8'h0A;
            2: b = tre_pkg::LETTER_BASE - 8'd1;
            3: b = tre_pkg::LETTER_BASE + 8'(N);
            default: b = 8'($urandom_range(0, 255));
        endcase
        // push lowercase letters up into the high half
        if (b >= tre_pkg::LETTER_BASE && b < tre_pkg::LETTER_BASE + N) begin
            b = b ^ 8'h80;
        end
        return b;
    endfunction

    task automatic shuffle(output int v [N]);
        int i;
        int j;
        int tmp;
        for (i = 0; i < N; i++) begin
            v[i] = i;
        end
        for (i = N - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            tmp  = v[i];
            v[i] = v[j];
            v[j] = tmp;
        end
    endtask

    // Write all three tables, entries in random order. Loose wiring may break the
    // permutation property; only allowed once every inverse entry has been written.
    task automatic queue_rewire(input bit loose);
        int order [N];
        int perm  [N];
        int wire_to [N];
        int t;
        int k;
        logic [1:0] sel;
        for (t = 0; t < 3; t++) begin
            sel = (t == 0) ? tre_pkg::SEL_ROTOR1
                : (t == 1) ? tre_pkg::SEL_ROTOR2 : tre_pkg::SEL_REFL;
            shuffle(order);
            shuffle(perm);
            if (loose && $urandom_range(0, 3) == 0) begin
                for (k = 0; k < N; k++) begin
                    wire_to[k] = $urandom_range(0, N - 1);
                end
            end else if (t == 2) begin
                // pair letters off, as a real reflector does
                for (k = 0; k < N; k += 2) begin
                    if (k + 1 < N) begin
                        wire_to[perm[k]]     = perm[k + 1];
                        wire_to[perm[k + 1]] = perm[k];
                    end else begin
                        wire_to[perm[k]] = perm[k];
                    end
                end
            end else begin
                for (k = 0; k < N; k++) begin
                    wire_to[k] = perm[k];
                end
            end
            for (k = 0; k < N; k++) begin
                push_load(sel, order[k], wire_to[order[k]]);
            end
        end
    endtask

    task automatic push_dropped_load();
        case ($urandom_range(0, 2))
            0: push_load(SEL_NONE, $urandom_range(0, 31), $urandom_range(0, 31));
            1: push_load(2'($urandom_range(0, 3)), $urandom_range(N, 31),
                         $urandom_range(0, 31));
            default: push_load(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                               $urandom_range(N, 31));
        endcase
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_beat(live_beat);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_hold > 0) begin
                    in_hold--;
                    i_in_valid <= 1'b0;
                end else if (beat_backlog.size() != 0) begin
                    live_beat = beat_backlog.pop_front();
                    i_cmd         <= live_beat.cmd;
                    i_table_sel   <= live_beat.sel;
                    i_entry_index <= live_beat.idx;
                    i_entry_value <= live_beat.val;
                    i_char_in     <= live_beat.ch;
                    i_in_valid    <= 1'b1;
                    if ($urandom_range(0, 31) == 0) begin
                        in_calm = !in_calm;
                    end
                    in_hold = in_calm ? 0 : $urandom_range(0, 7);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (char_expected.size() == 0) begin
                    mismatches++;
                    $display("%0t: char_out expected none, actual %02h", $time, o_char_out);
                end else if (o_char_out !== char_expected[0]) begin
                    mismatches++;
                    $display("%0t: char_out expected %02h, actual %02h", $time,
                             char_expected[0], o_char_out);
                    void'(char_expected.pop_front());
                end else begin
                    void'(char_expected.pop_front());
                end
                if ($urandom_range(0, 31) == 0) begin
                    out_calm = !out_calm;
                end
                out_hold = out_calm ? 0 : $urandom_range(0, 7);
            end
            if (out_hold > 0) begin
                out_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results pending", $time, char_expected.size());
            $display("two_rotor_enigma_cipher_top regression: fail");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        int base;
        int len;
        int k;
        int roll;

        // No wiring yet: only bytes that pass through and loads that get dropped.
        push_text(8'h00);
        push_text(8'hFF);
        push_text(tre_pkg::LETTER_BASE - 8'd1);
        push_text(tre_pkg::LETTER_BASE + 8'(N));
        push_text(" ");
        push_text(8'h0A);
        push_text("A");
        push_text(8'h80);
        push_load(SEL_NONE, 0, 0);
        push_load(SEL_NONE, 31, 31);
        push_load(tre_pkg::SEL_ROTOR1, N, 0);
        push_load(tre_pkg::SEL_ROTOR2, 31, 31);
        push_load(tre_pkg::SEL_REFL, 3, 31);
        push_load(tre_pkg::SEL_ROTOR1, 0, N);

        queue_rewire(1'b0);
        push_text("a");
        push_text("z");
        push_text(" ");
        push_text("m");
        push_load(SEL_NONE, N - 1, N - 1);          // dropped: positions hold
        push_text("a");
        push_text("z");
        push_load(tre_pkg::SEL_REFL, N - 1, 0);     // applied: positions clear
        push_text("a");

        base = stim_count;
        // one long message so rotor two walks all its positions and wraps
        for (k = 0; k < LONG_TEXT; k++) begin
            if ($urandom_range(0, 31) == 0) begin
                push_text(pick_symbol());
            end
            push_text(pick_letter());
        end
        while (stim_count - base < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 62) begin
                len = $urandom_range(1, 48);
                for (k = 0; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        push_text(pick_symbol());
                    end else begin
                        push_text(pick_letter());
                    end
                end
            end else if (roll < 82) begin
                push_load(2'($urandom_range(0, 2)), $urandom_range(0, N - 1),
                          $urandom_range(0, N - 1));
            end else if (roll < 95) begin
                len = $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    push_dropped_load();
                end
            end else begin
                queue_rewire(1'b1);
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (beat_backlog.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (char_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d beats in, %0d wiring writes applied, %0d letters, %0d results",
                 beats_in, loads_applied, letters_done, results_seen);
        $display("run: rotor two wrapped %0d time(s), %0d mismatch(es)",
                 rotor2_wraps, mismatches);
        if (mismatches == 0 && char_expected.size() == 0) begin
            $display("two_rotor_enigma_cipher_top regression: pass");
        end else begin
            $display("two_rotor_enigma_cipher_top regression: fail");
        end
        $finish;
    end

endmodule

// ===== two_rotor_enigma_cipher_top.f =====
+incdir+src
src/tre_pkg.sv
src/tre_ram.sv
src/two_rotor_enigma_cipher_top.sv
test/tb_two_rotor_enigma_cipher_top.sv
